@@ hw/rtl/stbs_pkg.sv @@
// types and constants for the sorted table search core
// no dependencies; imported by sorted_table_binary_search_core and tb_top
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PTR_W       = CNT_W + 1;
  localparam int VAL_W       = 32;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] operand_value;
  } stbs_req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic             table_full_error;
    logic [CNT_W-1:0] entry_count;
  } stbs_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_DONE = 3'b100
  } stbs_state_e;

endpackage

@@ hw/rtl/sorted_table_binary_search_core.sv @@
// sorted table with clear, append and binary search requests
// depends on stbs_pkg for types, codes and table depth
//
//  channel | signals                            | direction
//  req     | req_valid_i, req_stall_o, req_i    | in  (opcode, operand_value)
//  rsp     | rsp_valid_o, rsp_stall_i, rsp_o    | out (found, index, error, count)
//
// clear and append finish in the cycle they are taken; the response is
// registered, or parks while the output is stalled. a search reads the
// table memory once per probe (one synchronous read port), with at most
// log2(TABLE_DEPTH)+1 probes. one request is worked on at a time; a new
// one is taken while a finished response still waits in the output
// register.
// reset clears the entry count and control; table contents are undefined
// until written. a stalled response holds the output and a second finished
// result parks until the output frees up.
module sorted_table_binary_search_core
  import stbs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_stall_o,
  input  stbs_req_t req_i,
  output logic      rsp_valid_o,
  input  logic      rsp_stall_i,
  output stbs_rsp_t rsp_o
);

  // table memory
  logic [VAL_W-1:0] mem_q [TABLE_DEPTH];
  logic [VAL_W-1:0] rd_data_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;

  stbs_state_e             state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [PTR_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]        mid_q, mid_d;
  logic signed [VAL_W-1:0] key_q, key_d;
  stbs_rsp_t               park_q, park_d;
  logic                    rsp_valid_q, rsp_valid_d;
  stbs_rsp_t               rsp_q, rsp_d;

  logic                    req_fire;
  logic                    out_free;
  logic                    finish;
  stbs_rsp_t               fin_rsp;
  logic signed [PTR_W-1:0] mid_s, nlo, nhi;
  logic [PTR_W:0]          mid_sum;
  logic [CNT_W-1:0]        last_pos;
  logic signed [VAL_W-1:0] probe_val;

  assign req_fire    = req_valid_i && (state_q == S_IDLE);
  assign req_stall_o = (state_q != S_IDLE);
  assign out_free    = !rsp_valid_q || !rsp_stall_i;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign mid_s     = $signed({{(PTR_W-IDX_W){1'b0}}, mid_q});
  assign probe_val = $signed(rd_data_q);
  assign last_pos  = count_q - CNT_W'(1);
  assign wr_en     = req_fire && (req_i.opcode == OP_APPEND) &&
                     (count_q < CNT_W'(TABLE_DEPTH));

  // narrowed bounds after a miss, and the next midpoint
  always_comb begin
    nlo = lo_q;
    nhi = hi_q;
    if (probe_val > key_q) begin
      nhi = mid_s - PTR_W'(1);
    end else begin
      nlo = mid_s + PTR_W'(1);
    end
    mid_sum = {1'b0, nlo} + {1'b0, nhi};
  end

  // control and search sequencing
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    key_d       = key_q;
    park_d      = park_q;
    rd_en       = 1'b0;
    rd_addr     = mid_q;
    finish      = 1'b0;
    fin_rsp     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          key_d = req_i.operand_value;
          priority if (req_i.opcode == OP_CLEAR) begin
            count_d = '0;
            finish  = 1'b1;
          end else if (req_i.opcode == OP_APPEND) begin
            if (wr_en) begin
              count_d = count_q + CNT_W'(1);
            end else begin
              fin_rsp.table_full_error = 1'b1;
            end
            finish = 1'b1;
          end else if (req_i.opcode == OP_SEARCH && count_q != '0) begin
            lo_d    = '0;
            hi_d    = $signed({1'b0, last_pos});
            mid_d   = last_pos[IDX_W:1];
            rd_en   = 1'b1;
            rd_addr = mid_d;
            state_d = S_CMP;
          end else begin
            finish = 1'b1;
          end
          fin_rsp.entry_count = count_d;
        end
      end
      S_CMP: begin
        fin_rsp.entry_count = count_q;
        if (probe_val == key_q) begin
          fin_rsp.found       = 1'b1;
          fin_rsp.found_index = mid_q;
          finish              = 1'b1;
        end else if (nlo > nhi) begin
          finish = 1'b1;
        end else begin
          lo_d    = nlo;
          hi_d    = nhi;
          mid_d   = mid_sum[IDX_W:1];
          rd_en   = 1'b1;
          rd_addr = mid_d;
        end
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a result with nowhere to go parks until the output frees
    if (finish && !out_free) begin
      park_d  = fin_rsp;
      state_d = S_DONE;
    end
  end

  // output register
  always_comb begin
    rsp_valid_d = rsp_valid_q && rsp_stall_i;
    rsp_d       = rsp_q;
    if (state_q == S_DONE && out_free) begin
      rsp_valid_d = 1'b1;
      rsp_d       = park_q;
    end else if (finish && out_free) begin
      rsp_valid_d = 1'b1;
      rsp_d       = fin_rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    key_q  <= key_d;
    park_q <= park_d;
    rsp_q  <= rsp_d;
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[IDX_W-1:0]] <= req_i.operand_value;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> (lo_q <= hi_q) && (lo_q >= 0) &&
                         (hi_q < $signed({1'b0, count_q})))
    else $error("search bounds out of order");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.found |->
      {1'b0, rsp_o.found_index} < rsp_o.entry_count)
    else $error("hit index beyond entry count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.table_full_error |->
      rsp_o.entry_count == CNT_W'(TABLE_DEPTH) && !rsp_o.found)
    else $error("full error with table not full");

endmodule

@@ tb/tb_top.sv @@
// testbench for the sorted table search core: clear, append and search
// requests under random stalls, with an in-bench table model and checker
// depends on stbs_pkg and sorted_table_binary_search_core
`timescale 1ns / 1ps

module tb_top;
  import stbs_pkg::*;

  // request code with no function in the core
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned END_CYCLES  = 16;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      req_valid_i = 1'b0;
  logic      req_stall_o;
  stbs_req_t req_i       = '0;
  logic      rsp_valid_o;
  logic      rsp_stall_i = 1'b0;
  stbs_rsp_t rsp_o;

  sorted_table_binary_search_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

  // table model and pending responses
  logic signed [VAL_W-1:0] table_mem [TABLE_DEPTH];
  int                      held;
  stbs_rsp_t               rsp_pending_q [$];

  int unsigned send_gap_pct;
  int unsigned rsp_stall_pct;
  int unsigned err_count;
  int unsigned n_sent;
  int unsigned n_search;
  int unsigned n_hits;
  int unsigned n_full;
  int unsigned n_checked;
  int unsigned quiet_cycles;
  int unsigned max_held;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // next table state and response for one request
  function automatic stbs_rsp_t predict_rsp(stbs_req_t r);
    stbs_rsp_t e;
    int        lo;
    int        hi;
    int        mid;
    e = '0;
    case (r.opcode)
      OP_CLEAR: begin
        held = 0;
      end
      OP_APPEND: begin
        if (held >= TABLE_DEPTH) begin
          e.table_full_error = 1'b1;
        end else begin
          table_mem[held] = r.operand_value;
          held++;
        end
      end
      OP_SEARCH: begin
        lo = 0;
        hi = held - 1;
        while (lo <= hi && !e.found) begin
          mid = lo + (hi - lo) / 2;
          if (table_mem[mid] == r.operand_value) begin
            e.found       = 1'b1;
            e.found_index = mid[IDX_W-1:0];
          end else if (table_mem[mid] > r.operand_value) begin
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
      end
      default: ;
    endcase
    e.entry_count = held[CNT_W-1:0];
    return e;
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v)
      flag_error($sformatf("%s expected %0d got %0d (response %0d)",
                           name, exp_v, act_v, n_checked));
  endtask

  // sends one request, waits for it to be taken and logs its response
  // called and returns at a falling edge; valid stays high for the next one
  task automatic send_req(input logic [1:0] op, input logic signed [VAL_W-1:0] val);
    stbs_req_t r;
    stbs_rsp_t e;
    r.opcode        = op;
    r.operand_value = val;
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      req_valid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(0, 99) < send_gap_pct) @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do begin
      @(posedge clk_i);
    end while (req_stall_o);
    e = predict_rsp(r);
    rsp_pending_q.push_back(e);
    n_sent++;
    if (op == OP_SEARCH) n_search++;
    if (e.found) n_hits++;
    if (e.table_full_error) n_full++;
    if (held > max_held) max_held = held;
    @(negedge clk_i);
  endtask

  // sender holds off until every response is back
  task automatic drain_pause();
    req_valid_i <= 1'b0;
    @(negedge clk_i);
    while (rsp_pending_q.size() != 0) @(negedge clk_i);
  endtask

  // ascending values, wide spread over the whole range or narrow with repeats
  task automatic append_sorted(input int n, input bit narrow);
    longint      v;
    int unsigned span;
    v    = narrow ? longint'($signed($urandom())) : -64'sd2147483648 + $urandom_range(0, 3);
    span = narrow ? 3 : 32'hffff_ffff / (n + 1);
    for (int i = 0; i < n; i++) begin
      send_req(OP_APPEND, v[VAL_W-1:0]);
      if ($urandom_range(0, 5) != 0) v += longint'($urandom_range(0, span));
      if (v > 64'sd2147483647) v = 64'sd2147483647;
    end
  endtask

  // about half keys held in the table, some neighbors, extremes and noise
  function automatic logic signed [VAL_W-1:0] pick_key();
    logic signed [VAL_W-1:0] k;
    k = $urandom();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: if (held > 0) k = table_mem[$urandom_range(0, held - 1)];
      4: if (held > 0) k = table_mem[$urandom_range(0, held - 1)] + 1;
      5: if (held > 0) k = table_mem[$urandom_range(0, held - 1)] - 1;
      6: begin
        case ($urandom_range(0, 3))
          0: k = VAL_MIN;
          1: k = VAL_MAX;
          2: k = '0;
          default: k = -1;
        endcase
      end
      default: ;
    endcase
    return k;
  endfunction

  // response checker
  always @(posedge clk_i) begin
    stbs_rsp_t e;
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      if (rsp_pending_q.size() == 0) begin
        flag_error($sformatf("response with nothing pending, count %0d",
                             rsp_o.entry_count));
      end else begin
        e = rsp_pending_q.pop_front();
        check_field("found", e.found, rsp_o.found);
        check_field("found_index", e.found_index, rsp_o.found_index);
        check_field("table_full_error", e.table_full_error, rsp_o.table_full_error);
        check_field("entry_count", e.entry_count, rsp_o.entry_count);
      end
      n_checked++;
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    rsp_stall_i <= (rsp_stall_pct != 0) && ($urandom_range(0, 99) < rsp_stall_pct);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((req_valid_i && !req_stall_o) || (rsp_valid_o && !rsp_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // extremes, unused code, empty table, repeats and clear
  task automatic test_directed();
    send_req(OP_SEARCH, '0);
    send_req(OP_UNUSED, VAL_MAX);
    send_req(OP_APPEND, VAL_MIN);
    send_req(OP_APPEND, -1);
    send_req(OP_APPEND, '0);
    send_req(OP_APPEND, 2);
    send_req(OP_APPEND, VAL_MAX);
    send_req(OP_SEARCH, VAL_MIN);
    send_req(OP_SEARCH, VAL_MAX);
    send_req(OP_SEARCH, '0);
    send_req(OP_SEARCH, -1);
    send_req(OP_SEARCH, 2);
    send_req(OP_SEARCH, 1);
    send_req(OP_SEARCH, VAL_MIN + 1);
    send_req(OP_CLEAR, '0);
    send_req(OP_APPEND, 7);
    send_req(OP_APPEND, 7);
    send_req(OP_APPEND, 7);
    send_req(OP_SEARCH, 7);
    send_req(OP_CLEAR, -1);
    // old data stays in the store but must not be found
    send_req(OP_SEARCH, 7);
    send_req(OP_UNUSED, '0);
  endtask

  // short sorted tables, searches, stray appends and unused codes
  task automatic test_random_rounds(input int unsigned quota);
    int unsigned start;
    int          n;
    start = n_sent;
    while (n_sent - start < quota) begin
      if (held > 40 || $urandom_range(0, 9) < 7) send_req(OP_CLEAR, $urandom());
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
      append_sorted(n, $urandom_range(0, 2) == 0);
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 9))
          0: send_req(OP_UNUSED, $urandom());
          1: send_req(OP_APPEND, $urandom());  // breaks the ordering
          default: send_req(OP_SEARCH, pick_key());
        endcase
      end
      if ($urandom_range(0, 3) == 0) drain_pause();
    end
  endtask

  // fill to the full depth, push past it and search the whole range
  task automatic test_full_table();
    send_req(OP_CLEAR, $urandom());
    append_sorted(TABLE_DEPTH, 1'b0);
    send_req(OP_APPEND, $urandom());
    send_req(OP_APPEND, VAL_MAX);
    send_req(OP_SEARCH, table_mem[0]);
    send_req(OP_SEARCH, table_mem[TABLE_DEPTH-1]);
    repeat (60) send_req(OP_SEARCH, pick_key());
    send_req(OP_UNUSED, $urandom());
    send_req(OP_APPEND, $urandom());
    drain_pause();
    send_req(OP_CLEAR, $urandom());
    send_req(OP_SEARCH, table_mem[0]);
  endtask

  initial begin
    held          = 0;
    send_gap_pct  = 7;
    rsp_stall_pct = 86;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_rounds(60);
    send_gap_pct  = 86;
    rsp_stall_pct = 7;
    test_random_rounds(60);
    send_gap_pct  = 0;
    rsp_stall_pct = 0;
    test_random_rounds(60);
    test_full_table();

    drain_pause();
    repeat (END_CYCLES) @(posedge clk_i);
    if (rsp_pending_q.size() != 0)
      flag_error($sformatf("%0d responses never arrived", rsp_pending_q.size()));

    $display("run: %0d requests, %0d searches with %0d hits, %0d rejected appends",
             n_sent, n_search, n_hits, n_full);
    $display("run: %0d responses checked, table reached %0d entries, %0d errors",
             n_checked, max_held, err_count);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/stbs_pkg.sv
hw/rtl/sorted_table_binary_search_core.sv
tb/tb_top.sv
